FILE: design/imoe_pkg.sv
// shared types and constants for the integer matrix engine
// used by imoe_alu and integer_matrix_ops_engine_core; no dependencies
package imoe_pkg;

  localparam int DATA_W      = 32;
  localparam int IDX_W       = 3;
  localparam int DIM_W       = 4;
  localparam int KIND_W      = 2;
  localparam int MODE_W      = 2;
  localparam int CFG_AW      = 5;
  localparam int CFG_DW      = 32;
  localparam int REG_IDX_W   = 3;
  localparam int DEF_MAX_DIM = 8;

  localparam logic [DIM_W-1:0] DIM_RESET = 4'd8;

  // input word kinds
  localparam logic [KIND_W-1:0] KIND_WR_A = 2'd0;
  localparam logic [KIND_W-1:0] KIND_WR_B = 2'd1;
  localparam logic [KIND_W-1:0] KIND_RUN  = 2'd2;

  // operation modes
  localparam logic [MODE_W-1:0] OP_CMP = 2'd0;
  localparam logic [MODE_W-1:0] OP_ADD = 2'd1;
  localparam logic [MODE_W-1:0] OP_SUB = 2'd2;
  localparam logic [MODE_W-1:0] OP_MUL = 2'd3;

  // register map indexes
  localparam logic [REG_IDX_W-1:0] REG_OP_MODE = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_A_ROWS  = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_A_COLS  = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_B_ROWS  = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_B_COLS  = 3'd4;

  typedef enum logic [1:0] {
    ALU_ADD,
    ALU_SUB,
    ALU_MUL
  } alu_op_t;

endpackage

FILE: design/imoe_ram.sv
// generic single write port, single read port ram with registered read
// no dependencies
module imoe_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

FILE: design/imoe_alu.sv
// shared arithmetic unit: add, subtract, low word of multiply, equality
// depends on imoe_pkg
module imoe_alu import imoe_pkg::*; (
  input  alu_op_t           op,
  input  logic [DATA_W-1:0] x,
  input  logic [DATA_W-1:0] y,
  output logic [DATA_W-1:0] res,
  output logic              eq
);

  always_comb begin
    unique case (op)
      ALU_ADD: res = x + y;
      ALU_SUB: res = x - y;
      ALU_MUL: res = x * y;  // low 32 bits only
      default: res = x + y;
    endcase
  end

  assign eq = (x == y);

endmodule

FILE: design/integer_matrix_ops_engine_core.sv
// Integer matrix engine: words of kind 0/1 write one element of A or B. A run word starts
// the operation set in op_mode and blocks input until its last result is handed over.
// Compare and add/subtract take each element through a ram read, then one pass through
// the shared alu; multiply takes each multiply-accumulate through a read, a multiply into
// a product register and an accumulate through the same alu. Each result word passes
// through an emit state and waits there while the output register is held. No clearing
// pass after reset; entries read before they are written give undefined values.
// depends on imoe_pkg, imoe_ram, imoe_alu
module integer_matrix_ops_engine_core import imoe_pkg::*; #(
  parameter int MAX_DIM = DEF_MAX_DIM
) (
  input  logic                     clk,
  input  logic                     rst_n,
  // input words
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [KIND_W-1:0]        in_kind,
  input  logic [IDX_W-1:0]         in_row,
  input  logic [IDX_W-1:0]         in_col,
  input  logic signed [DATA_W-1:0] in_value,
  // result words
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [IDX_W-1:0]         out_row,
  output logic [IDX_W-1:0]         out_col,
  output logic signed [DATA_W-1:0] out_value,
  output logic                     out_equal,
  output logic                     out_invalid,
  output logic                     out_last,
  // register port
  input  logic                     cfg_psel,
  input  logic                     cfg_penable,
  input  logic                     cfg_pwrite,
  input  logic [CFG_AW-1:0]        cfg_paddr,
  input  logic [CFG_DW-1:0]        cfg_pwdata,
  output logic [CFG_DW-1:0]        cfg_prdata,
  output logic                     cfg_pready
);

  localparam int DEPTH = MAX_DIM * MAX_DIM;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_RD,
    S_EXE,
    S_ACC,
    S_EMIT
  } state_t;

  function automatic logic [AW-1:0] idx(input logic [IDX_W-1:0] r,
                                        input logic [IDX_W-1:0] c);
    return AW'(int'(r) * MAX_DIM + int'(c));
  endfunction

  function automatic logic dim_ok(input logic [DIM_W-1:0] d);
    return (d != '0) && (int'(d) <= MAX_DIM);
  endfunction

  state_t              state_r, state_nxt;
  logic [IDX_W-1:0]    r_r, r_nxt, c_r, c_nxt, i_r, i_nxt;
  logic [DATA_W-1:0]   acc_r, acc_nxt, prod_r, prod_nxt;
  logic                eq_r, eq_nxt;

  logic [IDX_W-1:0]    res_row_r, res_row_nxt, res_col_r, res_col_nxt;
  logic [DATA_W-1:0]   res_value_r, res_value_nxt;
  logic                res_equal_r, res_equal_nxt, res_invalid_r, res_invalid_nxt;
  logic                res_last_r, res_last_nxt;

  logic                out_valid_r, out_valid_nxt;
  logic [IDX_W-1:0]    out_row_r, out_row_nxt, out_col_r, out_col_nxt;
  logic [DATA_W-1:0]   out_value_r, out_value_nxt;
  logic                out_equal_r, out_equal_nxt, out_invalid_r, out_invalid_nxt;
  logic                out_last_r, out_last_nxt;

  logic [MODE_W-1:0]   op_mode_r, op_mode_nxt;
  logic [DIM_W-1:0]    a_rows_r, a_rows_nxt, a_cols_r, a_cols_nxt;
  logic [DIM_W-1:0]    b_rows_r, b_rows_nxt, b_cols_r, b_cols_nxt;

  logic                in_fire, out_free, in_range, cfg_we;
  logic [REG_IDX_W-1:0] cfg_idx;
  logic                dims_ok, same_size, row_last, col_last, k_last, is_mul;
  logic [DIM_W-1:0]    ncols;

  logic                a_we, b_we;
  logic [AW-1:0]       a_waddr, a_raddr, b_raddr, wr_addr;
  logic [DATA_W-1:0]   a_wdata, qa, qb;

  alu_op_t             alu_op;
  logic [DATA_W-1:0]   alu_x, alu_y, alu_res;
  logic                alu_eq;

  assign in_ready  = (state_r == S_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign out_free  = !out_valid_r || out_ready;
  assign in_range  = (int'(in_row) < MAX_DIM) && (int'(in_col) < MAX_DIM);

  assign is_mul    = (op_mode_r == OP_MUL);
  assign ncols     = is_mul ? b_cols_r : a_cols_r;
  assign dims_ok   = dim_ok(a_rows_r) && dim_ok(a_cols_r) &&
                     dim_ok(b_rows_r) && dim_ok(b_cols_r);
  assign same_size = (a_rows_r == b_rows_r) && (a_cols_r == b_cols_r);
  assign row_last  = ({1'b0, r_r} + 4'd1) == a_rows_r;
  assign col_last  = ({1'b0, c_r} + 4'd1) == ncols;
  assign k_last    = ({1'b0, i_r} + 4'd1) == a_cols_r;

  // ---- register port ----
  assign cfg_pready = 1'b1;
  assign cfg_idx    = cfg_paddr[CFG_AW-1:2];
  assign cfg_we     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_comb begin
    op_mode_nxt = op_mode_r;
    a_rows_nxt  = a_rows_r;
    a_cols_nxt  = a_cols_r;
    b_rows_nxt  = b_rows_r;
    b_cols_nxt  = b_cols_r;
    if (cfg_we) begin
      unique case (cfg_idx)
        REG_OP_MODE: op_mode_nxt = cfg_pwdata[MODE_W-1:0];
        REG_A_ROWS:  a_rows_nxt  = cfg_pwdata[DIM_W-1:0];
        REG_A_COLS:  a_cols_nxt  = cfg_pwdata[DIM_W-1:0];
        REG_B_ROWS:  b_rows_nxt  = cfg_pwdata[DIM_W-1:0];
        REG_B_COLS:  b_cols_nxt  = cfg_pwdata[DIM_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_OP_MODE: cfg_prdata = CFG_DW'(op_mode_r);
      REG_A_ROWS:  cfg_prdata = CFG_DW'(a_rows_r);
      REG_A_COLS:  cfg_prdata = CFG_DW'(a_cols_r);
      REG_B_ROWS:  cfg_prdata = CFG_DW'(b_rows_r);
      REG_B_COLS:  cfg_prdata = CFG_DW'(b_cols_r);
      default:     cfg_prdata = '0;
    endcase
  end

  // ---- matrix stores ----
  assign wr_addr = idx(in_row, in_col);
  assign a_raddr = is_mul ? idx(r_r, i_r) : idx(r_r, c_r);
  assign b_raddr = is_mul ? idx(i_r, c_r) : idx(r_r, c_r);

  // a is written by loads and by the add/subtract write-back
  always_comb begin
    a_we    = in_fire && (in_kind == KIND_WR_A) && in_range;
    a_waddr = wr_addr;
    a_wdata = in_value;
    if (state_r == S_EXE && (op_mode_r == OP_ADD || op_mode_r == OP_SUB)) begin
      a_we    = 1'b1;
      a_waddr = idx(r_r, c_r);
      a_wdata = alu_res;
    end
  end

  assign b_we = in_fire && (in_kind == KIND_WR_B) && in_range;

  imoe_ram #(.WIDTH(DATA_W), .DEPTH(DEPTH), .AW(AW)) u_ram_a (
    .clk   (clk),
    .we    (a_we),
    .waddr (a_waddr),
    .wdata (a_wdata),
    .raddr (a_raddr),
    .rdata (qa)
  );

  imoe_ram #(.WIDTH(DATA_W), .DEPTH(DEPTH), .AW(AW)) u_ram_b (
    .clk   (clk),
    .we    (b_we),
    .waddr (wr_addr),
    .wdata (in_value),
    .raddr (b_raddr),
    .rdata (qb)
  );

  // ---- shared alu ----
  always_comb begin
    alu_x = qa;
    alu_y = qb;
    if (state_r == S_ACC) begin
      alu_op = ALU_ADD;
      alu_x  = acc_r;
      alu_y  = prod_r;
    end else begin
      case (op_mode_r)
        OP_SUB:  alu_op = ALU_SUB;
        OP_MUL:  alu_op = ALU_MUL;
        default: alu_op = ALU_ADD;
      endcase
    end
  end

  imoe_alu u_alu (
    .op  (alu_op),
    .x   (alu_x),
    .y   (alu_y),
    .res (alu_res),
    .eq  (alu_eq)
  );

  // ---- sequencer ----
  always_comb begin
    state_nxt       = state_r;
    r_nxt           = r_r;
    c_nxt           = c_r;
    i_nxt           = i_r;
    acc_nxt         = acc_r;
    prod_nxt        = prod_r;
    eq_nxt          = eq_r;
    res_row_nxt     = res_row_r;
    res_col_nxt     = res_col_r;
    res_value_nxt   = res_value_r;
    res_equal_nxt   = res_equal_r;
    res_invalid_nxt = res_invalid_r;
    res_last_nxt    = res_last_r;
    out_valid_nxt   = out_valid_r && !out_ready;
    out_row_nxt     = out_row_r;
    out_col_nxt     = out_col_r;
    out_value_nxt   = out_value_r;
    out_equal_nxt   = out_equal_r;
    out_invalid_nxt = out_invalid_r;
    out_last_nxt    = out_last_r;

    unique case (state_r)
      S_IDLE: begin
        if (in_fire && in_kind == KIND_RUN) begin
          r_nxt           = '0;
          c_nxt           = '0;
          i_nxt           = '0;
          acc_nxt         = '0;
          eq_nxt          = 1'b1;
          res_row_nxt     = '0;
          res_col_nxt     = '0;
          res_value_nxt   = '0;
          res_equal_nxt   = 1'b0;
          res_invalid_nxt = 1'b0;
          res_last_nxt    = 1'b1;
          if (!dims_ok) begin
            res_invalid_nxt = 1'b1;
            state_nxt       = S_EMIT;
          end else begin
            unique case (op_mode_r) inside
              OP_CMP: begin
                // differing sizes compare unequal without a sweep
                state_nxt = same_size ? S_RD : S_EMIT;
              end
              OP_ADD, OP_SUB: begin
                res_invalid_nxt = !same_size;
                state_nxt       = same_size ? S_RD : S_EMIT;
              end
              default: begin
                res_invalid_nxt = (a_cols_r != b_rows_r);
                state_nxt       = (a_cols_r != b_rows_r) ? S_EMIT : S_RD;
              end
            endcase
          end
        end
      end

      S_RD: begin
        state_nxt = S_EXE;
      end

      S_EXE: begin
        unique case (op_mode_r) inside
          OP_CMP: begin
            eq_nxt = eq_r && alu_eq;
            if (row_last && col_last) begin
              res_equal_nxt = eq_r && alu_eq;
              state_nxt     = S_EMIT;
            end else begin
              c_nxt     = col_last ? '0 : c_r + 3'd1;
              r_nxt     = col_last ? r_r + 3'd1 : r_r;
              state_nxt = S_RD;
            end
          end
          OP_ADD, OP_SUB: begin
            res_row_nxt   = r_r;
            res_col_nxt   = c_r;
            res_value_nxt = alu_res;
            res_last_nxt  = row_last && col_last;
            state_nxt     = S_EMIT;
          end
          default: begin
            prod_nxt  = alu_res;
            state_nxt = S_ACC;
          end
        endcase
      end

      S_ACC: begin
        if (k_last) begin
          acc_nxt       = '0;
          i_nxt         = '0;
          res_row_nxt   = r_r;
          res_col_nxt   = c_r;
          res_value_nxt = alu_res;
          res_last_nxt  = row_last && col_last;
          state_nxt     = S_EMIT;
        end else begin
          acc_nxt   = alu_res;
          i_nxt     = i_r + 3'd1;
          state_nxt = S_RD;
        end
      end

      S_EMIT: begin
        if (out_free) begin
          out_valid_nxt   = 1'b1;
          out_row_nxt     = res_row_r;
          out_col_nxt     = res_col_r;
          out_value_nxt   = res_value_r;
          out_equal_nxt   = res_equal_r;
          out_invalid_nxt = res_invalid_r;
          out_last_nxt    = res_last_r;
          if (res_last_r) begin
            state_nxt = S_IDLE;
          end else begin
            c_nxt     = col_last ? '0 : c_r + 3'd1;
            r_nxt     = col_last ? r_r + 3'd1 : r_r;
            state_nxt = S_RD;
          end
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      op_mode_r   <= OP_CMP;
      a_rows_r    <= DIM_RESET;
      a_cols_r    <= DIM_RESET;
      b_rows_r    <= DIM_RESET;
      b_cols_r    <= DIM_RESET;
    end else begin
      state_r       <= state_nxt;
      out_valid_r   <= out_valid_nxt;
      op_mode_r     <= op_mode_nxt;
      a_rows_r      <= a_rows_nxt;
      a_cols_r      <= a_cols_nxt;
      b_rows_r      <= b_rows_nxt;
      b_cols_r      <= b_cols_nxt;
      r_r           <= r_nxt;
      c_r           <= c_nxt;
      i_r           <= i_nxt;
      acc_r         <= acc_nxt;
      prod_r        <= prod_nxt;
      eq_r          <= eq_nxt;
      res_row_r     <= res_row_nxt;
      res_col_r     <= res_col_nxt;
      res_value_r   <= res_value_nxt;
      res_equal_r   <= res_equal_nxt;
      res_invalid_r <= res_invalid_nxt;
      res_last_r    <= res_last_nxt;
      out_row_r     <= out_row_nxt;
      out_col_r     <= out_col_nxt;
      out_value_r   <= out_value_nxt;
      out_equal_r   <= out_equal_nxt;
      out_invalid_r <= out_invalid_nxt;
      out_last_r    <= out_last_nxt;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_row     = out_row_r;
  assign out_col     = out_col_r;
  assign out_value   = out_value_r;
  assign out_equal   = out_equal_r;
  assign out_invalid = out_invalid_r;
  assign out_last    = out_last_r;

  // ---- checks ----
  a_run_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && in_kind == KIND_RUN |=> !in_ready)
    else $error("input taken right after a run word");

  a_invalid_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_invalid |-> out_last && !out_equal)
    else $error("invalid word not alone");

  a_writeback_only_add_sub: assert property (@(posedge clk) disable iff (!rst_n)
    a_we |-> in_fire || (state_r == S_EXE && (op_mode_r == OP_ADD || op_mode_r == OP_SUB)))
    else $error("stray write to matrix a");

  a_emit_waits: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_value) && $stable(out_last))
    else $error("held result word overwritten");

endmodule
